[sv/gwsa_pkg.sv]
// Shared types, constants and state codes of the genome window signal accumulator.
package gwsa_pkg;

    localparam int WINDOWS_DEF = 32;

    localparam int CHROM_W = 16;
    localparam int POS_W   = 31;
    localparam int WS_W    = 21;
    localparam int SUPP_W  = 16;
    localparam int CNT_W   = 32;
    localparam int CLIP_W  = 20;
    localparam int CFGI_W  = 2;
    localparam int CFGD_W  = 32;

    localparam logic [WS_W-1:0]    WS_RESET       = 21'd1000;
    localparam logic [SUPP_W-1:0]  MIN_SUPP_RESET = 16'd3;
    localparam logic [CNT_W-1:0]   MIN_CLIP_RESET = 32'd50;
    localparam logic [CHROM_W:0]   NONE_CHROM     = 17'h10000;

    localparam logic [CFGI_W-1:0] CFG_WINDOW_SIZE = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_MIN_SUPP    = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_MIN_CLIP    = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIV,
        S_CHK,
        S_POP_RD,
        S_POP_CMP,
        S_POP_EMIT,
        S_WIN,
        S_FIND_RD,
        S_FIND_CMP,
        S_ADD,
        S_TRIG,
        S_OV_RD,
        S_OV_CMP,
        S_OV_DIV,
        S_STATUS
    } t_state;

    typedef struct packed {
        logic [CHROM_W-1:0] chrom;
        logic [POS_W-1:0]   start;
        logic [CNT_W-1:0]   covered;
        logic [SUPP_W-1:0]  supp;
        logic [CNT_W-1:0]   clipped;
        logic [CNT_W-1:0]   inserted;
        logic               trig;
    } t_entry;

    typedef struct packed {
        logic               window_valid;
        logic [CHROM_W-1:0] chrom;
        logic [POS_W-1:0]   start;
        logic [CNT_W-1:0]   covered;
        logic [SUPP_W-1:0]  supp;
        logic [CNT_W-1:0]   clipped;
        logic [CNT_W-1:0]   inserted;
        logic               overflow;
        logic               last;
    } t_result;

    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_ctl;

endpackage

[sv/genomic_window_signal_accumulator.sv]
// Top level of the genome window signal accumulator with its configuration registers.
// The block takes one request at a time. A seal or chromosome change pops the table head,
// reading and comparing each window and adding an emit step for each triggered window. A
// non-empty read first runs the remainder unit for its window alignment, then for each
// covered window scans the live entries with one memory read and one compare per entry and
// updates the entry with a read-modify-write; a read that overflows the table rescans it,
// running the remainder unit once per candidate entry. Every request ends with one status
// result. The table memory returns one entry per cycle. No clearing pass follows reset.
module genomic_window_signal_accumulator #(
    parameter int WINDOWS = gwsa_pkg::WINDOWS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_func,
    input  logic [gwsa_pkg::CHROM_W-1:0]   i_chrom,
    input  logic [gwsa_pkg::POS_W-1:0]     i_read_start,
    input  logic [gwsa_pkg::POS_W-1:0]     i_read_end,
    input  logic                           i_has_supplementary,
    input  logic [gwsa_pkg::CLIP_W-1:0]    i_read_clip_bases,
    input  logic [gwsa_pkg::CLIP_W-1:0]    i_read_insert_bases,
    input  logic [gwsa_pkg::POS_W-1:0]     i_seal_position,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_window_valid,
    output logic [gwsa_pkg::CHROM_W-1:0]   o_window_chrom,
    output logic [gwsa_pkg::POS_W-1:0]     o_window_start,
    output logic [gwsa_pkg::CNT_W-1:0]     o_covered_bases,
    output logic [gwsa_pkg::SUPP_W-1:0]    o_supplementary_reads,
    output logic [gwsa_pkg::CNT_W-1:0]     o_clipped_bases,
    output logic [gwsa_pkg::CNT_W-1:0]     o_inserted_bases,
    output logic                           o_table_overflow,
    output logic                           o_last,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [gwsa_pkg::CFGI_W-1:0]    i_cfg_index,
    input  logic [gwsa_pkg::CFGD_W-1:0]    i_cfg_data
);
    import gwsa_pkg::*;

    localparam int AW = $clog2(WINDOWS);

    logic [WS_W-1:0]   r_window_size;
    logic [SUPP_W-1:0] r_min_supp;
    logic [CNT_W-1:0]  r_min_clip;
    logic [WS_W-1:0]   ws;

    t_result           result;
    t_mem_ctl          mem_ctl;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    t_entry            mem_wdata, mem_rdata;
    logic              div_start, div_done;
    logic [POS_W-1:0]  div_dividend;
    logic [WS_W-1:0]   div_rem;

    assign o_cfg_ready = 1'b1;
    assign ws = (r_window_size == '0) ? WS_W'(1) : r_window_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WS_RESET;
            r_min_supp    <= MIN_SUPP_RESET;
            r_min_clip    <= MIN_CLIP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_WINDOW_SIZE: r_window_size <= i_cfg_data[WS_W-1:0];
                CFG_MIN_SUPP:    r_min_supp    <= i_cfg_data[SUPP_W-1:0];
                CFG_MIN_CLIP:    r_min_clip    <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    gwsa_rem_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (ws),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    gwsa_entry_mem #(.WINDOWS(WINDOWS)) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    gwsa_ctrl #(.WINDOWS(WINDOWS)) u_ctrl (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_ws                (ws),
        .i_min_supp          (r_min_supp),
        .i_min_clip          (r_min_clip),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_func              (i_func),
        .i_chrom             (i_chrom),
        .i_read_start        (i_read_start),
        .i_read_end          (i_read_end),
        .i_has_supplementary (i_has_supplementary),
        .i_read_clip_bases   (i_read_clip_bases),
        .i_read_insert_bases (i_read_insert_bases),
        .i_seal_position     (i_seal_position),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_result            (result),
        .o_mem_ctl           (mem_ctl),
        .o_mem_waddr         (mem_waddr),
        .o_mem_wdata         (mem_wdata),
        .o_mem_raddr         (mem_raddr),
        .i_mem_rdata         (mem_rdata),
        .o_div_start         (div_start),
        .o_div_dividend      (div_dividend),
        .i_div_done          (div_done),
        .i_div_rem           (div_rem)
    );

    assign o_window_valid        = result.window_valid;
    assign o_window_chrom        = result.chrom;
    assign o_window_start        = result.start;
    assign o_covered_bases       = result.covered;
    assign o_supplementary_reads = result.supp;
    assign o_clipped_bases       = result.clipped;
    assign o_inserted_bases      = result.inserted;
    assign o_table_overflow      = result.overflow;
    assign o_last                = result.last;

endmodule

[sv/gwsa_rem_div.sv]
// Iterative restoring remainder unit, one dividend bit per cycle.
module gwsa_rem_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [gwsa_pkg::POS_W-1:0] i_dividend,
    input  logic [gwsa_pkg::WS_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [gwsa_pkg::WS_W-1:0]  o_rem
);
    import gwsa_pkg::*;

    localparam int CW = $clog2(POS_W);

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [WS_W-1:0] r_rem, n_rem;
    logic [POS_W-1:0] r_dvd, n_dvd;
    logic [WS_W:0]   trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        trial  = {r_rem, r_dvd[POS_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_dvd  = i_dividend;
        end else if (r_busy) begin
            if (trial >= {1'b0, i_divisor}) begin
                trial = trial - {1'b0, i_divisor};
            end
            n_rem = trial[WS_W-1:0];
            n_dvd = {r_dvd[POS_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(POS_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dvd <= n_dvd;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[sv/gwsa_entry_mem.sv]
// Window table memory with one write port and one registered read port.
module gwsa_entry_mem #(
    parameter int WINDOWS = gwsa_pkg::WINDOWS_DEF
) (
    input  logic                         i_clk,
    input  gwsa_pkg::t_mem_ctl           i_ctl,
    input  logic [$clog2(WINDOWS)-1:0]   i_waddr,
    input  gwsa_pkg::t_entry             i_wdata,
    input  logic [$clog2(WINDOWS)-1:0]   i_raddr,
    output gwsa_pkg::t_entry             o_rdata
);
    import gwsa_pkg::*;

    t_entry r_mem [WINDOWS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.rd) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/gwsa_ctrl.sv]
// Sequencer that walks the window table, updates entries and emits results.
module gwsa_ctrl #(
    parameter int WINDOWS = gwsa_pkg::WINDOWS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [gwsa_pkg::WS_W-1:0]      i_ws,
    input  logic [gwsa_pkg::SUPP_W-1:0]    i_min_supp,
    input  logic [gwsa_pkg::CNT_W-1:0]     i_min_clip,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_func,
    input  logic [gwsa_pkg::CHROM_W-1:0]   i_chrom,
    input  logic [gwsa_pkg::POS_W-1:0]     i_read_start,
    input  logic [gwsa_pkg::POS_W-1:0]     i_read_end,
    input  logic                           i_has_supplementary,
    input  logic [gwsa_pkg::CLIP_W-1:0]    i_read_clip_bases,
    input  logic [gwsa_pkg::CLIP_W-1:0]    i_read_insert_bases,
    input  logic [gwsa_pkg::POS_W-1:0]     i_seal_position,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output gwsa_pkg::t_result              o_result,
    output gwsa_pkg::t_mem_ctl             o_mem_ctl,
    output logic [$clog2(WINDOWS)-1:0]     o_mem_waddr,
    output gwsa_pkg::t_entry               o_mem_wdata,
    output logic [$clog2(WINDOWS)-1:0]     o_mem_raddr,
    input  gwsa_pkg::t_entry               i_mem_rdata,
    output logic                           o_div_start,
    output logic [gwsa_pkg::POS_W-1:0]     o_div_dividend,
    input  logic                           i_div_done,
    input  logic [gwsa_pkg::WS_W-1:0]      i_div_rem
);
    import gwsa_pkg::*;

    localparam int AW  = $clog2(WINDOWS);
    localparam int CW  = $clog2(WINDOWS + 1);
    localparam int SPW = WS_W + CW;

    t_state r_state, n_state;
    logic               r_func, n_func;
    logic [CHROM_W-1:0] r_chrom, n_chrom;
    logic [POS_W-1:0]   r_rs, n_rs;
    logic [POS_W-1:0]   r_re, n_re;
    logic               r_supp, n_supp;
    logic [CLIP_W-1:0]  r_clip, n_clip;
    logic [CLIP_W-1:0]  r_ins, n_ins;
    logic [POS_W-1:0]   r_seal, n_seal;
    logic [CHROM_W:0]   r_active, n_active;
    logic [AW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_live, n_live;
    logic [CW-1:0]      r_i, n_i;
    logic [AW-1:0]      r_slot, n_slot;
    t_entry             r_ent, n_ent;
    logic [CNT_W-1:0]   r_cur, n_cur;
    logic [CNT_W-1:0]   r_brk, n_brk;
    logic               r_ovf, n_ovf;
    logic               r_ovscan, n_ovscan;
    logic               r_ovalid, n_ovalid;
    t_result            r_out, n_out;

    logic               in_acc;
    logic               out_free;
    logic [AW:0]        slot_sum;
    logic [AW-1:0]      slot_i;
    logic [AW:0]        tail_sum;
    logic [AW-1:0]      tail;
    logic [AW-1:0]      head_inc;
    logic               pop_cond;
    logic               find_hit;
    logic               ov_cand;
    logic [CNT_W-1:0]   start_first;
    logic [SPW-1:0]     span;
    logic [CNT_W:0]     span_end;
    logic [CNT_W-1:0]   wend, hi, lo, ovl;
    logic [CNT_W:0]     cov_sum, clip_sum, ins_sum;
    logic [CNT_W+3:0]   clip_x10;
    logic               trig_hit;
    t_entry             wr_ent;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_ovalid || i_out_ready;
    assign slot_sum = (AW+1)'(r_head) + (AW+1)'(r_i);
    assign slot_i   = (slot_sum >= (AW+1)'(WINDOWS)) ?
                      AW'(slot_sum - (AW+1)'(WINDOWS)) : slot_sum[AW-1:0];
    assign tail_sum = (AW+1)'(r_head) + (AW+1)'(r_live);
    assign tail     = (tail_sum >= (AW+1)'(WINDOWS)) ?
                      AW'(tail_sum - (AW+1)'(WINDOWS)) : tail_sum[AW-1:0];
    assign head_inc = (r_head == AW'(WINDOWS - 1)) ? '0 : r_head + 1'b1;
    assign pop_cond = !r_func || (i_mem_rdata.start < r_seal);
    assign find_hit = (i_mem_rdata.chrom == r_chrom) && ({1'b0, i_mem_rdata.start} == r_cur);
    assign ov_cand  = (i_mem_rdata.chrom == r_chrom) && ({1'b0, i_mem_rdata.start} > r_brk)
                      && (i_mem_rdata.start < r_re);
    assign start_first = {1'b0, r_rs} - {11'b0, i_div_rem};
    assign span        = SPW'(i_ws) * SPW'(WINDOWS);
    assign span_end    = {1'b0, start_first} + (CNT_W+1)'(span);

    assign wend     = {1'b0, r_ent.start} + {11'b0, i_ws};
    assign hi       = ({1'b0, r_re} < wend) ? {1'b0, r_re} : wend;
    assign lo       = (r_rs > r_ent.start) ? {1'b0, r_rs} : {1'b0, r_ent.start};
    assign ovl      = (hi > lo) ? hi - lo : '0;
    assign cov_sum  = {1'b0, r_ent.covered} + {1'b0, ovl};
    assign clip_sum = {1'b0, r_ent.clipped} + (CNT_W+1)'(r_clip);
    assign ins_sum  = {1'b0, r_ent.inserted} + (CNT_W+1)'(r_ins);
    assign clip_x10 = ({4'b0, r_ent.clipped} << 3) + ({4'b0, r_ent.clipped} << 1);
    assign trig_hit = (r_ent.supp >= i_min_supp) || (r_ent.clipped >= i_min_clip)
                      || ((r_ent.covered != '0) && (clip_x10 > {4'b0, r_ent.covered}));

    always_comb begin
        wr_ent      = r_ent;
        wr_ent.trig = r_ent.trig || trig_hit;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_func) begin
                        n_state = S_POP_RD;
                    end else if (i_read_start < i_read_end) begin
                        n_state = S_DIV;
                    end else begin
                        n_state = S_STATUS;
                    end
                end
            end
            S_DIV: begin
                if (i_div_done) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_state = (r_active != {1'b0, r_chrom}) ? S_POP_RD : S_WIN;
            end
            S_POP_RD: begin
                if (r_live == '0) begin
                    n_state = r_func ? S_STATUS : S_WIN;
                end else begin
                    n_state = S_POP_CMP;
                end
            end
            S_POP_CMP: begin
                if (!pop_cond) begin
                    n_state = S_STATUS;
                end else if (i_mem_rdata.trig) begin
                    n_state = S_POP_EMIT;
                end else begin
                    n_state = S_POP_RD;
                end
            end
            S_POP_EMIT: begin
                if (out_free) begin
                    n_state = S_POP_RD;
                end
            end
            S_WIN: begin
                n_state = (r_cur >= {1'b0, r_re}) ? S_STATUS : S_FIND_RD;
            end
            S_FIND_RD: begin
                if (r_i == r_live) begin
                    n_state = (r_live == CW'(WINDOWS)) ? S_OV_RD : S_ADD;
                end else begin
                    n_state = S_FIND_CMP;
                end
            end
            S_FIND_CMP: begin
                n_state = find_hit ? S_ADD : S_FIND_RD;
            end
            S_ADD: begin
                n_state = S_TRIG;
            end
            S_TRIG: begin
                n_state = r_ovscan ? S_OV_RD : S_WIN;
            end
            S_OV_RD: begin
                n_state = (r_i == r_live) ? S_STATUS : S_OV_CMP;
            end
            S_OV_CMP: begin
                n_state = ov_cand ? S_OV_DIV : S_OV_RD;
            end
            S_OV_DIV: begin
                if (i_div_done) begin
                    n_state = (i_div_rem == '0) ? S_ADD : S_OV_RD;
                end
            end
            S_STATUS: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_func   = r_func;
        n_chrom  = r_chrom;
        n_rs     = r_rs;
        n_re     = r_re;
        n_supp   = r_supp;
        n_clip   = r_clip;
        n_ins    = r_ins;
        n_seal   = r_seal;
        n_active = r_active;
        n_head   = r_head;
        n_live   = r_live;
        n_i      = r_i;
        n_slot   = r_slot;
        n_ent    = r_ent;
        n_cur    = r_cur;
        n_brk    = r_brk;
        n_ovf    = r_ovf;
        n_ovscan = r_ovscan;
        n_out    = r_out;
        n_ovalid = r_ovalid && !i_out_ready;
        o_mem_ctl      = '0;
        o_mem_raddr    = slot_i;
        o_mem_waddr    = r_slot;
        o_mem_wdata    = wr_ent;
        o_div_start    = 1'b0;
        o_div_dividend = i_mem_rdata.start;
        o_in_ready     = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                o_div_dividend = i_read_start;
                if (in_acc) begin
                    n_func   = i_func;
                    n_chrom  = i_chrom;
                    n_rs     = i_read_start;
                    n_re     = i_read_end;
                    n_supp   = i_has_supplementary;
                    n_clip   = i_read_clip_bases;
                    n_ins    = i_read_insert_bases;
                    n_seal   = i_seal_position;
                    n_ovf    = 1'b0;
                    n_ovscan = 1'b0;
                    o_div_start = !i_func && (i_read_start < i_read_end);
                end
            end
            S_DIV: begin
            end
            S_CHK: begin
                n_cur = start_first;
                if (r_active != {1'b0, r_chrom}) begin
                    n_ovf = (span_end < (CNT_W+1)'(r_re));
                end
            end
            S_POP_RD: begin
                o_mem_raddr = r_head;
                if (r_live == '0) begin
                    if (!r_func) begin
                        n_active = {1'b0, r_chrom};
                    end
                end else begin
                    o_mem_ctl.rd = 1'b1;
                end
            end
            S_POP_CMP: begin
                n_ent = i_mem_rdata;
                if (pop_cond) begin
                    n_head = head_inc;
                    n_live = r_live - 1'b1;
                end
            end
            S_POP_EMIT: begin
                if (out_free) begin
                    n_ovalid           = 1'b1;
                    n_out.window_valid = 1'b1;
                    n_out.chrom        = r_ent.chrom;
                    n_out.start        = r_ent.start;
                    n_out.covered      = r_ent.covered;
                    n_out.supp         = r_ent.supp;
                    n_out.clipped      = r_ent.clipped;
                    n_out.inserted     = r_ent.inserted;
                    n_out.overflow     = r_ovf;
                    n_out.last         = 1'b0;
                end
            end
            S_WIN: begin
                n_i = '0;
            end
            S_FIND_RD: begin
                if (r_i == r_live) begin
                    if (r_live == CW'(WINDOWS)) begin
                        n_ovf    = 1'b1;
                        n_ovscan = 1'b1;
                        n_brk    = r_cur;
                        n_i      = '0;
                    end else begin
                        n_slot      = tail;
                        n_ent       = '0;
                        n_ent.chrom = r_chrom;
                        n_ent.start = r_cur[POS_W-1:0];
                        n_live      = r_live + 1'b1;
                    end
                end else begin
                    o_mem_ctl.rd = 1'b1;
                end
            end
            S_FIND_CMP: begin
                if (find_hit) begin
                    n_slot = slot_i;
                    n_ent  = i_mem_rdata;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_ADD: begin
                n_ent.covered  = cov_sum[CNT_W] ? '1 : cov_sum[CNT_W-1:0];
                n_ent.clipped  = clip_sum[CNT_W] ? '1 : clip_sum[CNT_W-1:0];
                n_ent.inserted = ins_sum[CNT_W] ? '1 : ins_sum[CNT_W-1:0];
                if (r_supp && (r_ent.supp != '1)) begin
                    n_ent.supp = r_ent.supp + 1'b1;
                end
            end
            S_TRIG: begin
                o_mem_ctl.wr = 1'b1;
                n_ent        = wr_ent;
                if (r_ovscan) begin
                    n_i = r_i + 1'b1;
                end else begin
                    n_cur = r_cur + {11'b0, i_ws};
                end
            end
            S_OV_RD: begin
                o_mem_ctl.rd = (r_i != r_live);
            end
            S_OV_CMP: begin
                n_ent  = i_mem_rdata;
                n_slot = slot_i;
                if (ov_cand) begin
                    o_div_start = 1'b1;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_OV_DIV: begin
                if (i_div_done && (i_div_rem != '0)) begin
                    n_i = r_i + 1'b1;
                end
            end
            S_STATUS: begin
                if (out_free) begin
                    n_ovalid       = 1'b1;
                    n_out          = '0;
                    n_out.overflow = r_ovf;
                    n_out.last     = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= NONE_CHROM;
            r_head   <= '0;
            r_live   <= '0;
            r_ovalid <= 1'b0;
            r_ovf    <= 1'b0;
            r_ovscan <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_head   <= n_head;
            r_live   <= n_live;
            r_ovalid <= n_ovalid;
            r_ovf    <= n_ovf;
            r_ovscan <= n_ovscan;
        end
        r_func  <= n_func;
        r_chrom <= n_chrom;
        r_rs    <= n_rs;
        r_re    <= n_re;
        r_supp  <= n_supp;
        r_clip  <= n_clip;
        r_ins   <= n_ins;
        r_seal  <= n_seal;
        r_i     <= n_i;
        r_slot  <= n_slot;
        r_ent   <= n_ent;
        r_cur   <= n_cur;
        r_brk   <= n_brk;
        r_out   <= n_out;
    end

    assign o_out_valid = r_ovalid;
    assign o_result    = r_out;

endmodule

[tb/genomic_window_signal_accumulator_tb.sv]
// Self-checking testbench of the genome window accumulator: a window table predictor with random traffic.
module genomic_window_signal_accumulator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gwsa_pkg::*;

    localparam int NW = WINDOWS_DEF;
    localparam longint CYCLE_LIMIT = 20000000;

    typedef struct {
        logic               wv;
        logic [CHROM_W-1:0] chrom;
        logic [POS_W-1:0]   start;
        logic [CNT_W-1:0]   cov;
        logic [SUPP_W-1:0]  supp;
        logic [CNT_W-1:0]   clip;
        logic [CNT_W-1:0]   ins;
        logic               ovf;
        logic               last;
    } t_win_res;

    class t_window_scoreboard;
        logic [WS_W-1:0]    cfg_ws;
        logic [SUPP_W-1:0]  cfg_min_supp;
        logic [CNT_W-1:0]   cfg_min_clip;
        logic [CHROM_W-1:0] t_chrom [NW];
        longint             t_start [NW];
        longint             t_cov [NW];
        longint             t_supp [NW];
        longint             t_clip [NW];
        longint             t_ins [NW];
        bit                 t_trig [NW];
        int                 head;
        int                 live;
        logic [CHROM_W:0]   cur_chrom;
        t_win_res           pending [$];
        int                 errors;
        int                 checked;
        int                 emitted;
        int                 overflows;

        function new();
            cfg_ws = WS_RESET;
            cfg_min_supp = MIN_SUPP_RESET;
            cfg_min_clip = MIN_CLIP_RESET;
            head = 0;
            live = 0;
            cur_chrom = NONE_CHROM;
            errors = 0;
            checked = 0;
            emitted = 0;
            overflows = 0;
        endfunction

        function void write_reg(logic [CFGI_W-1:0] idx, logic [CFGD_W-1:0] d);
            if (idx == CFG_WINDOW_SIZE) cfg_ws = d[WS_W-1:0];
            else if (idx == CFG_MIN_SUPP) cfg_min_supp = d[SUPP_W-1:0];
            else if (idx == CFG_MIN_CLIP) cfg_min_clip = d;
        endfunction

        function longint sat(longint a, longint b, longint mx);
            return (a + b > mx) ? mx : a + b;
        endfunction

        function void add_to(int s, longint rs, longint re, longint ws, bit sp,
                             longint cl, longint in);
            longint hi, lo;
            hi = (re < t_start[s] + ws) ? re : t_start[s] + ws;
            lo = (rs > t_start[s]) ? rs : t_start[s];
            if (hi > lo) t_cov[s] = sat(t_cov[s], hi - lo, 64'hFFFFFFFF);
            if (sp) t_supp[s] = sat(t_supp[s], 1, 64'hFFFF);
            t_clip[s] = sat(t_clip[s], cl, 64'hFFFFFFFF);
            t_ins[s] = sat(t_ins[s], in, 64'hFFFFFFFF);
            if (!t_trig[s] && (t_supp[s] >= cfg_min_supp || t_clip[s] >= cfg_min_clip ||
                               (t_cov[s] > 0 && t_clip[s] * 10 > t_cov[s])))
                t_trig[s] = 1;
        endfunction

        function void pop_oldest(ref t_win_res q [$]);
            t_win_res r;
            if (t_trig[head]) begin
                r.wv = 1; r.chrom = t_chrom[head]; r.start = t_start[head];
                r.cov = t_cov[head]; r.supp = t_supp[head]; r.clip = t_clip[head];
                r.ins = t_ins[head]; r.ovf = 0; r.last = 0;
                q = {q, r};
                emitted++;
            end
            head = (head + 1) % NW;
            live--;
        endfunction

        function void note_request(bit fn, logic [CHROM_W-1:0] ch, longint rs, longint re,
                                   bit sp, longint cl, longint in, longint sealp);
            t_win_res q [$];
            t_win_res r;
            longint ws, idx, lidx, st;
            bit ovf;
            int s;
            ovf = 0;
            ws = (cfg_ws == 0) ? 1 : cfg_ws;
            if (fn) begin
                while (live > 0 && t_start[head] < sealp) pop_oldest(q);
            end else if (rs < re) begin
                if (cur_chrom != {1'b0, ch}) begin
                    if (cur_chrom != NONE_CHROM)
                        while (live > 0 && {1'b0, t_chrom[head]} == cur_chrom) pop_oldest(q);
                    cur_chrom = {1'b0, ch};
                end
                idx = rs / ws;
                lidx = (re - 1) / ws;
                while (idx <= lidx) begin
                    st = idx * ws;
                    s = -1;
                    for (int i = 0; i < live; i++)
                        if (s < 0 && t_chrom[(head + i) % NW] == ch &&
                            t_start[(head + i) % NW] == st) s = (head + i) % NW;
                    if (s < 0) begin
                        if (live >= NW) begin
                            ovf = 1;
                            break;
                        end
                        s = (head + live) % NW;
                        t_chrom[s] = ch; t_start[s] = st; t_cov[s] = 0; t_supp[s] = 0;
                        t_clip[s] = 0; t_ins[s] = 0; t_trig[s] = 0;
                        live++;
                    end
                    add_to(s, rs, re, ws, sp, cl, in);
                    idx++;
                end
                if (ovf) begin
                    overflows++;
                    for (int i = 0; i < live; i++) begin
                        s = (head + i) % NW;
                        if (t_chrom[s] == ch && t_start[s] % ws == 0 &&
                            t_start[s] / ws > idx && t_start[s] / ws <= lidx)
                            add_to(s, rs, re, ws, sp, cl, in);
                    end
                end
            end
            r = '{default: 0};
            r.last = 1;
            q = {q, r};
            foreach (q[k]) begin
                q[k].ovf = ovf;
                pending = {pending, q[k]};
            end
        endfunction

        function void check_result(t_win_res a);
            t_win_res e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result wv=%0d last=%0d", a.wv, a.last);
                return;
            end
            e = pending[0];
            pending.delete(0);
            checked++;
            if (a.wv !== e.wv || a.chrom !== e.chrom || a.start !== e.start ||
                a.cov !== e.cov || a.supp !== e.supp || a.clip !== e.clip ||
                a.ins !== e.ins || a.ovf !== e.ovf || a.last !== e.last) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch exp wv=%0d ch=%0d st=%0d cov=%0d sp=%0d cl=%0d ",
                              "in=%0d ov=%0d l=%0d | act wv=%0d ch=%0d st=%0d cov=%0d ",
                              "sp=%0d cl=%0d in=%0d ov=%0d l=%0d"},
                             e.wv, e.chrom, e.start, e.cov, e.supp, e.clip, e.ins, e.ovf,
                             e.last, a.wv, a.chrom, a.start, a.cov, a.supp, a.clip, a.ins,
                             a.ovf, a.last);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_in_valid = 0, o_in_ready;
    logic i_func = 0;
    logic [CHROM_W-1:0] i_chrom = 0;
    logic [POS_W-1:0] i_read_start = 0, i_read_end = 0, i_seal_position = 0;
    logic i_has_supplementary = 0;
    logic [CLIP_W-1:0] i_read_clip_bases = 0, i_read_insert_bases = 0;
    logic o_out_valid, i_out_ready = 0;
    logic o_window_valid, o_table_overflow, o_last;
    logic [CHROM_W-1:0] o_window_chrom;
    logic [POS_W-1:0] o_window_start;
    logic [CNT_W-1:0] o_covered_bases, o_clipped_bases, o_inserted_bases;
    logic [SUPP_W-1:0] o_supplementary_reads;
    logic i_cfg_valid = 0, o_cfg_ready;
    logic [CFGI_W-1:0] i_cfg_index = 0;
    logic [CFGD_W-1:0] i_cfg_data = 0;

    genomic_window_signal_accumulator dut (.*);

    always #6 i_clk = ~i_clk;

    t_window_scoreboard sb = new();
    longint cycles = 0;
    bit stall_long = 0;
    int n_items = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_win_res a;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            a.wv = o_window_valid; a.chrom = o_window_chrom; a.start = o_window_start;
            a.cov = o_covered_bases; a.supp = o_supplementary_reads;
            a.clip = o_clipped_bases; a.ins = o_inserted_bases;
            a.ovf = o_table_overflow; a.last = o_last;
            sb.check_result(a);
        end
    end

    initial begin
        int hold;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (stall_long) begin
                i_out_ready <= 0;
                repeat (600) @(posedge i_clk);
                stall_long = 0;
            end else if ($urandom_range(0, 3) == 0) begin
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                   : $urandom_range(1, 3);
                i_out_ready <= 0;
                repeat (hold - 1) @(posedge i_clk);
            end else begin
                i_out_ready <= 1;
            end
        end
    end

    task automatic idle_gap();
        int g;
        if ($urandom_range(0, 2) == 0) begin
            g = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic send_request(bit fn, logic [CHROM_W-1:0] ch, logic [POS_W-1:0] rs,
                                logic [POS_W-1:0] re, bit sp, logic [CLIP_W-1:0] cl,
                                logic [CLIP_W-1:0] in, logic [POS_W-1:0] sealp);
        @(posedge i_clk);
        i_in_valid <= 1; i_func <= fn; i_chrom <= ch; i_read_start <= rs;
        i_read_end <= re; i_has_supplementary <= sp; i_read_clip_bases <= cl;
        i_read_insert_bases <= in; i_seal_position <= sealp;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(fn, ch, rs, re, sp, cl, in, sealp);
        n_items++;
        i_in_valid <= 0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        while (!o_in_ready && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFGI_W-1:0] idx, logic [CFGD_W-1:0] d);
        @(posedge i_clk);
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, d);
        i_cfg_valid <= 0;
    endtask

    task automatic send_read(logic [CHROM_W-1:0] ch, int span);
        logic [POS_W-1:0] rs;
        longint ws, re;
        ws = (sb.cfg_ws == 0) ? 1 : sb.cfg_ws;
        rs = $urandom_range(0, span);
        re = rs + $urandom_range(1, ws * 3);
        if (re > 32'h7FFFFFFF) re = 32'h7FFFFFFF;
        send_request(0, ch, rs, POS_W'(re), $urandom_range(0, 1),
                     ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 30),
                     $urandom, 0);
    endtask

    initial begin
        logic [CHROM_W-1:0] ch;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_request(0, 0, 0, 1, 0, 0, 0, 0);
        send_request(0, 0, 5, 5, 1, 5, 5, 0);
        send_request(0, 0, 900, 2100, 1, 20'hFFFFF, 20'hFFFFF, 0);
        send_request(0, 0, 950, 1200, 1, 7, 0, 0);
        send_request(0, 0, 10, 60, 0, 0, 3, 0);
        send_request(1, 16'hFFFF, 31'h7FFFFFFF, 0, 1, 20'hFFFFF, 20'hFFFFF, 1500);
        send_request(0, 7, 31'h7FFFF000, 31'h7FFFFFFF, 1, 1, 1, 31'h7FFFFFFF);
        send_request(0, 16'hFFFF, 100, 300, 0, 0, 0, 0);
        send_request(1, 0, 0, 0, 0, 0, 0, 31'h7FFFFFFF);
        send_request(0, 3, 0, 40000, 0, 0, 0, 0);
        send_request(0, 3, 39000, 40500, 1, 2, 2, 0);
        send_request(1, 0, 0, 0, 0, 0, 0, 0);
        send_request(1, 0, 0, 0, 0, 0, 0, 31'h7FFFFFFF);
        drain();

        write_reg(CFG_WINDOW_SIZE, 0);
        write_reg(CFG_MIN_SUPP, 16'hFFFF);
        write_reg(CFG_MIN_CLIP, 32'hFFFFFFFF);
        send_request(0, 1, 0, 20, 1, 1, 0, 0);
        send_request(0, 1, 10, 50, 0, 0, 0, 0);
        send_request(0, 2, 0, 1, 0, 0, 1, 0);
        send_request(1, 0, 0, 0, 0, 0, 0, 31'h7FFFFFFF);
        drain();

        write_reg(CFG_WINDOW_SIZE, 21'h100000);
        write_reg(CFG_MIN_SUPP, 0);
        write_reg(CFG_MIN_CLIP, 0);
        send_request(0, 4, 31'h7FF00000, 31'h7FFFFFFF, 0, 0, 0, 0);
        send_request(1, 0, 0, 0, 0, 0, 0, 31'h7FFFFFFF);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin write_reg(CFG_WINDOW_SIZE, 1000); write_reg(CFG_MIN_SUPP, 3);
                         write_reg(CFG_MIN_CLIP, 50); end
                1: begin write_reg(CFG_WINDOW_SIZE, 1); write_reg(CFG_MIN_SUPP, 2);
                         write_reg(CFG_MIN_CLIP, 200); end
                2: begin write_reg(CFG_WINDOW_SIZE, $urandom_range(16, 5000));
                         write_reg(CFG_MIN_SUPP, $urandom_range(0, 6));
                         write_reg(CFG_MIN_CLIP, $urandom); end
                default: begin write_reg(CFG_WINDOW_SIZE, 21'h1FFFFF);
                         write_reg(CFG_MIN_SUPP, 16'hFFFF); write_reg(CFG_MIN_CLIP, 1); end
            endcase
            ch = $urandom;
            for (int k = 0; k < 70; k++) begin
                if (ph == 1 && k == 20) stall_long = 1;
                idle_gap();
                case ($urandom_range(0, 19))
                    0: send_request(1, $urandom, $urandom, $urandom, $urandom,
                                    $urandom, $urandom, $urandom);
                    1: send_request(1, 0, 0, 0, 0, 0, 0,
                                    ($urandom_range(0, 1) == 0) ? 31'h7FFFFFFF : $urandom);
                    2: begin ch = ($urandom_range(0, 1) == 0) ? ch + 1 : $urandom;
                             send_read(ch, 40000); end
                    3: send_request(0, ch, $urandom, $urandom_range(0, 1000), $urandom,
                                    $urandom, $urandom, $urandom);
                    4: send_read(ch, ($urandom_range(0, 3) == 0) ? 31'h7FFF0000 : 200000);
                    default: send_read(ch, (ph == 1) ? 60 : 40000);
                endcase
                if (k == 50) drain();
            end
            send_request(1, 0, 0, 0, 0, 0, 0, 31'h7FFFFFFF);
            drain();
        end

        $display("covered %0d requests, %0d results checked, %0d windows emitted, %0d overflows",
                 n_items, sb.checked, sb.emitted, sb.overflows);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d results outstanding", sb.errors, sb.pending.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
